FILE: hw/rtl/order_statistic_multiset_macros.svh
// assertion macros for the order statistic multiset
`ifndef ORDER_STATISTIC_MULTISET_MACROS_SVH
`define ORDER_STATISTIC_MULTISET_MACROS_SVH

// plain property under the block clock and reset
`define OSM_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("osm assertion failed");

// overlapping implication under the block clock and reset
`define OSM_ASSERT_IMP(name, clk, rst_n, pre, post) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("osm implication failed");

`endif

FILE: hw/rtl/osm_pkg.sv
// shared types and constants of the order statistic multiset
package osm_pkg;

  localparam int unsigned ValW        = 31;
  localparam int unsigned RankW       = 11;
  localparam int unsigned OccW        = 11;
  localparam int unsigned DefCapacity = 1024;

  localparam logic OpInsert = 1'b0;
  localparam logic OpTake   = 1'b1;

  typedef enum logic [1:0] {
    StInserted = 2'd0,
    StTaken    = 2'd1,
    StFull     = 2'd2,
    StBadRank  = 2'd3
  } status_e;

  typedef struct packed {
    logic            ins_en;
    logic            del_en;
    logic [ValW-1:0] key;
  } cell_cmd_t;

endpackage

FILE: hw/rtl/osm_if.sv
// request and response channel interfaces
interface osm_req_if import osm_pkg::*;;
  logic             valid;
  logic             ready;
  logic             operation;
  logic [ValW-1:0]  new_value;
  logic [RankW-1:0] rank;

  modport source (output valid, operation, new_value, rank, input ready);
  modport sink (input valid, operation, new_value, rank, output ready);
endinterface

interface osm_rsp_if import osm_pkg::*;;
  logic            valid;
  logic            ready;
  logic [ValW-1:0] taken_value;
  logic [1:0]      status;
  logic [OccW-1:0] occupancy;

  modport source (output valid, taken_value, status, occupancy, input ready);
  modport sink (input valid, taken_value, status, occupancy, output ready);
endinterface

FILE: hw/rtl/osm_or_tree.sv
// registered or-reduction tree that gathers the one selected cell value
module osm_or_tree import osm_pkg::*; #(
  parameter int unsigned N = DefCapacity
) (
  input  logic            clk_i,
  input  logic [ValW-1:0] leaf_i [N],
  output logic [ValW-1:0] root_o
);

  localparam int unsigned Lvl = $clog2(N);
  localparam int unsigned P   = 1 << Lvl;

  logic [ValW-1:0] node_q [1:2*P-1];

  for (genvar i = 0; i < P; i++) begin : g_leaf
    if (i < N) begin : g_used
      always_ff @(posedge clk_i) begin
        node_q[P+i] <= leaf_i[i];
      end
    end else begin : g_pad
      always_ff @(posedge clk_i) begin
        node_q[P+i] <= '0;
      end
    end
  end

  for (genvar j = 1; j < P; j++) begin : g_node
    always_ff @(posedge clk_i) begin
      node_q[j] <= node_q[2*j] | node_q[2*j+1];
    end
  end

  assign root_o = node_q[1];

endmodule

FILE: hw/rtl/osm_cell.sv
// one sorted-store cell: holds a value, shifts toward a neighbor on insert or take
module osm_cell import osm_pkg::*; #(
  parameter int unsigned IdxW = 10,
  parameter int unsigned Idx  = 0
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  cell_cmd_t       cmd_i,
  input  logic [IdxW-1:0] del_pos_i,
  input  logic [ValW-1:0] prev_val_i,
  input  logic            prev_vld_i,
  input  logic            prev_lt_i,
  input  logic [ValW-1:0] next_val_i,
  input  logic            next_vld_i,
  output logic [ValW-1:0] val_o,
  output logic            vld_o,
  output logic            lt_o,
  output logic [ValW-1:0] tap_o
);

  logic [ValW-1:0] val_q, val_d;
  logic            vld_q, vld_d;
  logic            sel, shift;

  assign lt_o  = vld_q && (val_q < cmd_i.key);
  assign sel   = (del_pos_i == IdxW'(Idx));
  assign shift = (del_pos_i <= IdxW'(Idx));

  always_comb begin
    val_d = val_q;
    vld_d = vld_q;
    if (cmd_i.ins_en && !lt_o) begin
      val_d = prev_lt_i ? cmd_i.key : prev_val_i;
      vld_d = vld_q | prev_vld_i;
    end else if (cmd_i.del_en && shift) begin
      val_d = next_val_i;
      vld_d = next_vld_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign val_o = val_q;
  assign vld_o = vld_q;
  assign tap_o = (sel && vld_q) ? val_q : '0;

endmodule

FILE: hw/rtl/order_statistic_multiset.sv
// insert: an accepted word goes straight to the done state and commits into the response register
// take: an accepted word waits in the wait state while the or-tree settles, then commits the same way
// the take wait is set by the registered or-tree that gathers the selected cell
// one word is in flight at a time; the response register frees the input side
// reset empties the store at once through the cell valid bits, no clearing pass
`include "order_statistic_multiset_macros.svh"

module order_statistic_multiset import osm_pkg::*; #(
  parameter int unsigned CAPACITY = DefCapacity
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  osm_req_if.sink      req_i,
  osm_rsp_if.source    rsp_o
);

  localparam int unsigned IdxW    = $clog2(CAPACITY);
  localparam int unsigned CntW    = $clog2(CAPACITY + 1);
  localparam int unsigned TreeLvl = $clog2(CAPACITY);
  localparam int unsigned WaitW   = $clog2(TreeLvl + 1);
  localparam int unsigned CmpW    = (CntW > RankW) ? CntW : RankW;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StWait = 2'd1;
  localparam logic [1:0] StDone = 2'd2;

  logic [1:0]       state_q, state_d;
  logic [WaitW-1:0] wait_q, wait_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             op_q;
  logic [ValW-1:0]  value_q;
  logic [RankW-1:0] rank_q;
  logic             rsp_vld_q, rsp_vld_d;
  logic [ValW-1:0]  rsp_val_q, rsp_val_d;
  logic [1:0]       rsp_st_q, rsp_st_d;
  logic [OccW-1:0]  rsp_occ_q, rsp_occ_d;

  logic             accept, commit, full, rank_ok;
  logic [RankW-1:0] rank_m1;
  logic [IdxW-1:0]  del_pos;
  cell_cmd_t        cmd;
  logic [ValW-1:0]  root;

  logic [ValW-1:0]  cval [CAPACITY];
  logic             cvld [CAPACITY];
  logic             clt  [CAPACITY];
  logic [ValW-1:0]  ctap [CAPACITY];

  assign req_i.ready = (state_q == StIdle);
  assign accept      = req_i.valid && req_i.ready;
  assign commit      = (state_q == StDone) && (!rsp_vld_q || rsp_o.ready);

  assign full    = (count_q == CntW'(CAPACITY));
  assign rank_ok = (rank_q != '0) && (CmpW'(rank_q) <= CmpW'(count_q));
  assign rank_m1 = rank_q - RankW'(1);
  assign del_pos = IdxW'(rank_m1);

  assign cmd.ins_en = commit && (op_q == OpInsert) && !full;
  assign cmd.del_en = commit && (op_q == OpTake) && rank_ok;
  assign cmd.key    = value_q;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [ValW-1:0] pv, nv;
    logic            pvld, plt, nvld;
    if (i == 0) begin : g_first
      assign pv   = '0;
      assign pvld = 1'b1;
      assign plt  = 1'b1;
    end else begin : g_mid
      assign pv   = cval[i-1];
      assign pvld = cvld[i-1];
      assign plt  = clt[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign nv   = '0;
      assign nvld = 1'b0;
    end else begin : g_inner
      assign nv   = cval[i+1];
      assign nvld = cvld[i+1];
    end
    osm_cell #(
      .IdxW (IdxW),
      .Idx  (i)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cmd_i      (cmd),
      .del_pos_i  (del_pos),
      .prev_val_i (pv),
      .prev_vld_i (pvld),
      .prev_lt_i  (plt),
      .next_val_i (nv),
      .next_vld_i (nvld),
      .val_o      (cval[i]),
      .vld_o      (cvld[i]),
      .lt_o       (clt[i]),
      .tap_o      (ctap[i])
    );
  end

  osm_or_tree #(
    .N (CAPACITY)
  ) u_tree (
    .clk_i  (clk_i),
    .leaf_i (ctap),
    .root_o (root)
  );

  always_comb begin
    state_d   = state_q;
    wait_d    = wait_q;
    count_d   = count_q;
    rsp_vld_d = rsp_vld_q;
    rsp_val_d = rsp_val_q;
    rsp_st_d  = rsp_st_q;
    rsp_occ_d = rsp_occ_q;
    if (rsp_vld_q && rsp_o.ready) begin
      rsp_vld_d = 1'b0;
    end
    case (state_q)
      StIdle: begin
        if (accept) begin
          wait_d  = '0;
          state_d = (req_i.operation == OpTake) ? StWait : StDone;
        end
      end
      StWait: begin
        wait_d = wait_q + WaitW'(1);
        if (wait_q == WaitW'(TreeLvl)) begin
          state_d = StDone;
        end
      end
      StDone: begin
        if (commit) begin
          rsp_vld_d = 1'b1;
          rsp_val_d = '0;
          if (op_q == OpInsert) begin
            if (full) begin
              rsp_st_d = StFull;
            end else begin
              rsp_st_d = StInserted;
              count_d  = count_q + CntW'(1);
            end
          end else if (rank_ok) begin
            rsp_st_d  = StTaken;
            rsp_val_d = root;
            count_d   = count_q - CntW'(1);
          end else begin
            rsp_st_d = StBadRank;
          end
          rsp_occ_d = OccW'(count_d);
          state_d   = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      wait_q    <= '0;
      count_q   <= '0;
      rsp_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      wait_q    <= wait_d;
      count_q   <= count_d;
      rsp_vld_q <= rsp_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_val_q <= rsp_val_d;
    rsp_st_q  <= rsp_st_d;
    rsp_occ_q <= rsp_occ_d;
    if (accept) begin
      op_q    <= req_i.operation;
      value_q <= req_i.new_value;
      rank_q  <= req_i.rank;
    end
  end

  assign rsp_o.valid       = rsp_vld_q;
  assign rsp_o.taken_value = rsp_val_q;
  assign rsp_o.status      = rsp_st_q;
  assign rsp_o.occupancy   = rsp_occ_q;

  `OSM_ASSERT(a_count_bound, clk_i, rst_ni, count_q <= CntW'(CAPACITY))
  `OSM_ASSERT_IMP(a_count_moves_on_commit, clk_i, rst_ni, count_q != $past(count_q), $past(commit))
  `OSM_ASSERT_IMP(a_take_bad_zero, clk_i, rst_ni, rsp_vld_q && (rsp_st_q != StTaken), rsp_val_q == '0)

endmodule

FILE: dv/tb_order_statistic_multiset.sv
// testbench for order_statistic_multiset: random insert and take words checked against a sorted shadow store
module tb_order_statistic_multiset import osm_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CAPACITY   = DefCapacity;
  localparam int unsigned MaxRank    = (1 << RankW) - 1;
  localparam int unsigned CycleLimit = 1_000_000;

  typedef struct {
    logic             operation;
    logic [ValW-1:0]  new_value;
    logic [RankW-1:0] rank;
    int unsigned      gap;
  } req_word_t;

  typedef struct {
    logic [ValW-1:0] taken_value;
    status_e         status;
    logic [OccW-1:0] occupancy;
  } rsp_word_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  osm_req_if req_if ();
  osm_rsp_if rsp_if ();

  order_statistic_multiset #(
    .CAPACITY(CAPACITY)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  always #10 clk_i = ~clk_i;

  req_word_t       pending_q[$];
  rsp_word_t       expected_q[$];
  logic [ValW-1:0] shadow_store[$];

  req_word_t   next_word;
  rsp_word_t   due;
  int unsigned words_total;
  int unsigned words_accepted;
  int unsigned idle_left;
  int unsigned stall_left;
  int unsigned calm_left;
  int unsigned ready_roll;
  logic        hold_done;
  int unsigned gen_occ;
  int unsigned burst_left;
  int unsigned cycle_count;
  int unsigned errors;
  int unsigned n_inserted, n_taken, n_full, n_bad_rank, peak_occ;

  // sorted shadow of the store, one word at a time
  function automatic rsp_word_t predict_word(logic op, logic [ValW-1:0] val,
                                             logic [RankW-1:0] rnk);
    rsp_word_t   r;
    int unsigned pos;
    r.taken_value = '0;
    if (op == OpInsert) begin
      if (shadow_store.size() >= CAPACITY) begin
        r.status = StFull;
      end else begin
        pos = 0;
        while (pos < shadow_store.size() && shadow_store[pos] < val) pos++;
        shadow_store.insert(pos, val);
        r.status = StInserted;
      end
    end else begin
      if (rnk == '0 || rnk > shadow_store.size()) begin
        r.status = StBadRank;
      end else begin
        r.taken_value = shadow_store[rnk - 1];
        shadow_store.delete(rnk - 1);
        r.status = StTaken;
      end
    end
    r.occupancy = OccW'(shadow_store.size());
    return r;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (burst_left != 0) begin
      burst_left--;
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 2) begin
      burst_left = $urandom_range(20, 80);
      return 0;
    end
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [ValW-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2, 3, 4: return ValW'($urandom_range(0, 15));
      default: return ValW'($urandom());
    endcase
  endfunction

  function automatic int unsigned pick_rank(int unsigned occ);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (occ == 0 || roll < 10) begin
      case ($urandom_range(0, 3))
        0:       return 0;
        1:       return MaxRank;
        2:       return (occ < MaxRank) ? occ + 1 : MaxRank;
        default: return (occ < MaxRank) ? $urandom_range(occ + 1, MaxRank) : 0;
      endcase
    end
    if (roll < 15) return 1;
    if (roll < 20) return occ;
    return $urandom_range(1, occ);
  endfunction

  task automatic queue_insert(logic [ValW-1:0] val);
    req_word_t w;
    w.operation = OpInsert;
    w.new_value = val;
    w.rank      = RankW'($urandom());
    w.gap       = pick_gap();
    pending_q.push_back(w);
    if (gen_occ < CAPACITY) gen_occ++;
  endtask

  task automatic queue_take(int unsigned rnk);
    req_word_t w;
    w.operation = OpTake;
    w.new_value = ValW'($urandom());
    w.rank      = RankW'(rnk);
    w.gap       = pick_gap();
    pending_q.push_back(w);
    if (rnk != 0 && rnk <= gen_occ) gen_occ--;
  endtask

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_if.valid     <= 1'b0;
      req_if.operation <= OpInsert;
      req_if.new_value <= '0;
      req_if.rank      <= '0;
      idle_left        <= 0;
      words_accepted   <= 0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        expected_q.push_back(predict_word(req_if.operation, req_if.new_value, req_if.rank));
        words_accepted <= words_accepted + 1;
      end
      if (!req_if.valid || req_if.ready) begin
        if (idle_left != 0) begin
          idle_left    <= idle_left - 1;
          req_if.valid <= 1'b0;
        end else if (pending_q.size() != 0) begin
          next_word        = pending_q.pop_front();
          req_if.operation <= next_word.operation;
          req_if.new_value <= next_word.new_value;
          req_if.rank      <= next_word.rank;
          req_if.valid     <= 1'b1;
          idle_left        <= next_word.gap;
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // response ready with random stalls and one long hold-off
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
      stall_left   <= 0;
      calm_left    <= 0;
      hold_done    <= 1'b0;
    end else if (!hold_done && words_accepted >= 120) begin
      hold_done    <= 1'b1;
      stall_left   <= 400;
      rsp_if.ready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left   <= stall_left - 1;
      rsp_if.ready <= 1'b0;
    end else if (calm_left != 0) begin
      calm_left    <= calm_left - 1;
      rsp_if.ready <= 1'b1;
    end else begin
      ready_roll = $urandom_range(0, 99);
      if (ready_roll < 3) begin
        calm_left    <= $urandom_range(40, 150);
        rsp_if.ready <= 1'b1;
      end else if (ready_roll < 78) begin
        rsp_if.ready <= 1'b1;
      end else if (ready_roll < 95) begin
        stall_left   <= $urandom_range(0, 3);
        rsp_if.ready <= 1'b0;
      end else begin
        stall_left   <= $urandom_range(10, 40);
        rsp_if.ready <= 1'b0;
      end
    end
  end

  // response monitor
  always @(posedge clk_i) begin
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (expected_q.size() == 0) begin
        $error("response word with nothing expected");
        errors++;
      end else begin
        due = expected_q.pop_front();
        if (rsp_if.taken_value !== due.taken_value) begin
          $error("taken_value: expected %0d, got %0d", due.taken_value, rsp_if.taken_value);
          errors++;
        end
        if (rsp_if.status !== due.status) begin
          $error("status: expected %0d, got %0d", due.status, rsp_if.status);
          errors++;
        end
        if (rsp_if.occupancy !== due.occupancy) begin
          $error("occupancy: expected %0d, got %0d", due.occupancy, rsp_if.occupancy);
          errors++;
        end
        case (due.status)
          StInserted: n_inserted++;
          StTaken:    n_taken++;
          StFull:     n_full++;
          default:    n_bad_rank++;
        endcase
        if (due.occupancy > peak_occ) peak_occ = due.occupancy;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    int unsigned i;
    req_if.valid     = 1'b0;
    req_if.operation = OpInsert;
    req_if.new_value = '0;
    req_if.rank      = '0;
    rsp_if.ready     = 1'b0;
    rst_ni           = 1'b0;
    gen_occ          = 0;
    burst_left       = 0;
    cycle_count      = 0;
    errors           = 0;
    n_inserted       = 0;
    n_taken          = 0;
    n_full           = 0;
    n_bad_rank       = 0;
    peak_occ         = 0;

    // directed: empty store, rank zero, ranks past the end, extremes, duplicates
    queue_take(1);
    queue_take(0);
    queue_insert('1);
    queue_insert('0);
    queue_insert(ValW'(5));
    queue_insert(ValW'(5));
    queue_insert(ValW'(32'h4000_0000));
    queue_insert(ValW'(3));
    queue_take(0);
    queue_take(MaxRank);
    queue_take(1024);
    queue_take(7);
    queue_take(6);
    queue_take(1);
    queue_take(2);
    queue_insert(ValW'(32'h2AAA_AAAA));
    queue_insert(ValW'(32'h5555_5555));
    queue_take(2);
    queue_take(3);
    queue_take(1);
    queue_take(1);
    queue_take(1);

    // mixed traffic
    for (i = 0; i < 300; i++) begin
      if ($urandom_range(0, 99) < 55) queue_insert(pick_value());
      else queue_take(pick_rank(gen_occ));
    end
    // fill to capacity, then churn around full
    while (gen_occ < CAPACITY) queue_insert(pick_value());
    for (i = 0; i < 40; i++) begin
      if ($urandom_range(0, 1) == 0) queue_insert(pick_value());
      else queue_take(pick_rank(gen_occ));
    end
    while (gen_occ < CAPACITY) queue_insert(pick_value());
    for (i = 0; i < 6; i++) queue_insert(pick_value());
    // mostly drain
    for (i = 0; i < 200; i++) begin
      if ($urandom_range(0, 99) < 20) queue_insert(pick_value());
      else queue_take(pick_rank(gen_occ));
    end
    words_total = pending_q.size();

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (words_accepted != words_total) @(posedge clk_i);
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("ran %0d words: %0d inserted, %0d taken, %0d dropped on full, %0d bad ranks",
             words_total, n_inserted, n_taken, n_full, n_bad_rank);
    $display("peak occupancy %0d of %0d, %0d mismatches", peak_occ, CAPACITY, errors);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
